>>> rtl/pkcs_pkg.sv
// Shared types, constants and DigestInfo prefix tables for the PKCS#1 v1.5 padding checker.
// No dependencies; every other rtl file refers to it by scoped names.
package pkcs_pkg;

    // Longest supported modulus in bytes.
    localparam int MAX_KEY_BYTES = 1024;
    // The position counter saturates at MAX_KEY_BYTES + 1.
    localparam int POS_W         = $clog2(MAX_KEY_BYTES + 2);
    localparam int KEY_W         = 11;
    localparam int DLEN_W        = 7;
    // Signed width for layout arithmetic (position, key size, separator index).
    localparam int ARITH_W       = ((POS_W > KEY_W) ? POS_W : KEY_W) + 2;
    localparam int PFX_IDX_W     = 5;
    localparam int PFX_LEN_W     = 5;

    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 11;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_SELECT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGEST_LEN  = 2'd2;

    // Register reset values
    localparam logic [KEY_W-1:0]  RST_KEY_BYTES   = 11'd128;
    localparam logic              RST_HASH_SELECT = 1'b1;
    localparam logic [DLEN_W-1:0] RST_DIGEST_LEN  = 7'd20;

    // Fault codes
    localparam logic [2:0] FLT_OK        = 3'd0;
    localparam logic [2:0] FLT_LENGTH    = 3'd1;
    localparam logic [2:0] FLT_HEADER    = 3'd2;
    localparam logic [2:0] FLT_SHORT_KEY = 3'd3;
    localparam logic [2:0] FLT_PAD       = 3'd4;
    localparam logic [2:0] FLT_SEP       = 3'd5;
    localparam logic [2:0] FLT_PREFIX    = 3'd6;
    localparam logic [2:0] FLT_DIGEST    = 3'd7;

    localparam logic [7:0] BYTE_ZERO     = 8'h00;
    localparam logic [7:0] BYTE_ONE      = 8'h01;
    localparam logic [7:0] PAD_BYTE      = 8'hFF;
    // Minimum key_bytes - prefix - digest: 00 01, at least seven pad bytes, 00.
    localparam int         SHORT_MARGIN  = 10;

    localparam logic [PFX_LEN_W-1:0] PFX_LEN_MD5  = 5'd18;
    localparam logic [PFX_LEN_W-1:0] PFX_LEN_SHA1 = 5'd15;

    typedef struct packed {
        logic [7:0] block_byte;
        logic [7:0] digest_byte;
        logic       last;
    } t_in;

    typedef struct packed {
        logic       pass;
        logic [2:0] fault;
    } t_out;

    typedef struct packed {
        logic [KEY_W-1:0]  key_bytes;
        logic              hash_select;
        logic [DLEN_W-1:0] digest_len;
    } t_cfg;

    // One classified byte on its way from the front to the back.
    typedef struct packed {
        logic [7:0] block_byte;
        logic [7:0] exp_byte;
        logic [2:0] chk_fault;   // fault code on mismatch, FLT_OK when unchecked
        logic       last;
        logic       len_bad;
        logic       short_key;
    } t_qent;

    function automatic logic [PFX_LEN_W-1:0] prefix_len(input logic sel);
        prefix_len = sel ? PFX_LEN_SHA1 : PFX_LEN_MD5;
    endfunction

    function automatic logic [7:0] prefix_byte(input logic sel,
                                               input logic [PFX_IDX_W-1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (sel) begin
            case (idx)
                5'd0:    b = 8'h30;
                5'd1:    b = 8'h21;
                5'd2:    b = 8'h30;
                5'd3:    b = 8'h09;
                5'd4:    b = 8'h06;
                5'd5:    b = 8'h05;
                5'd6:    b = 8'h2B;
                5'd7:    b = 8'h0E;
                5'd8:    b = 8'h03;
                5'd9:    b = 8'h02;
                5'd10:   b = 8'h1A;
                5'd11:   b = 8'h05;
                5'd12:   b = 8'h00;
                5'd13:   b = 8'h04;
                5'd14:   b = 8'h14;
                default: b = 8'h00;
            endcase
        end else begin
            case (idx)
                5'd0:    b = 8'h30;
                5'd1:    b = 8'h20;
                5'd2:    b = 8'h30;
                5'd3:    b = 8'h0C;
                5'd4:    b = 8'h06;
                5'd5:    b = 8'h08;
                5'd6:    b = 8'h2A;
                5'd7:    b = 8'h86;
                5'd8:    b = 8'h48;
                5'd9:    b = 8'h86;
                5'd10:   b = 8'hF7;
                5'd11:   b = 8'h0D;
                5'd12:   b = 8'h02;
                5'd13:   b = 8'h05;
                5'd14:   b = 8'h05;
                5'd15:   b = 8'h00;
                5'd16:   b = 8'h04;
                5'd17:   b = 8'h10;
                default: b = 8'h00;
            endcase
        end
        prefix_byte = b;
    endfunction

endpackage

>>> rtl/pkcs1_v15_padding_checker_core.sv
// Top level of the EMSA-PKCS1-v1_5 signature padding checker: config registers,
// classifying front, queue and checking back. Depends on pkcs_pkg and the pkcs_* modules.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+---------------------------------------
//   input    | i_in_valid / o_in_ready      | i_in_data  (block_byte, digest_byte, last)
//   result   | o_out_valid / i_out_ready    | o_out_data (pass, fault)
//   config   | i_cfg_we                     | i_cfg_idx, i_cfg_wdata
//
// One byte is accepted per cycle while the queue is not full; the front classifies
// it in the accept cycle. The verdict for a block is loaded into the output register
// as its last byte leaves the 4-entry queue, which the byte enters when it is
// accepted; o_out_valid is driven from that output register.
// Reset (synchronous, active low) clears the position, the first fault, the queue and
// the output valid, and loads the key size, hash select and digest length defaults.
// A stalled result holds back only last bytes; other bytes keep draining. The input
// stalls once the queue is full: the held last byte and three bytes behind it.
module pkcs1_v15_padding_checker_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  pkcs_pkg::t_in                     i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output pkcs_pkg::t_out                    o_out_data,
    input  logic                              i_cfg_we,
    input  logic [pkcs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pkcs_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    pkcs_pkg::t_cfg  r_cfg;
    pkcs_pkg::t_cfg  n_cfg;
    pkcs_pkg::t_qent push_entry;
    pkcs_pkg::t_qent head_entry;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                pkcs_pkg::CFG_KEY_BYTES:   n_cfg.key_bytes   = i_cfg_wdata[pkcs_pkg::KEY_W-1:0];
                pkcs_pkg::CFG_HASH_SELECT: n_cfg.hash_select = i_cfg_wdata[0];
                pkcs_pkg::CFG_DIGEST_LEN:  n_cfg.digest_len  = i_cfg_wdata[pkcs_pkg::DLEN_W-1:0];
                default:                   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_bytes   <= pkcs_pkg::RST_KEY_BYTES;
            r_cfg.hash_select <= pkcs_pkg::RST_HASH_SELECT;
            r_cfg.digest_len  <= pkcs_pkg::RST_DIGEST_LEN;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    pkcs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .i_full  (q_full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    pkcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_rdata (head_entry)
    );

    pkcs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_entry (head_entry),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

>>> rtl/pkcs_front.sv
// Front end: accepts block bytes, tracks the byte position and classifies each byte
// into its layout field with the expected value. Depends on pkcs_pkg.
module pkcs_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pkcs_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  pkcs_pkg::t_in   i_data,
    input  logic            i_full,
    output logic            o_push,
    output pkcs_pkg::t_qent o_entry
);

    logic [pkcs_pkg::POS_W-1:0]          r_pos;
    logic [pkcs_pkg::POS_W-1:0]          n_pos;
    logic [pkcs_pkg::POS_W-1:0]          count_next;
    logic                                in_range;
    logic signed [pkcs_pkg::ARITH_W-1:0] s_pos;
    logic signed [pkcs_pkg::ARITH_W-1:0] s_key;
    logic signed [pkcs_pkg::ARITH_W-1:0] s_pl;
    logic signed [pkcs_pkg::ARITH_W-1:0] s_dl;
    logic signed [pkcs_pkg::ARITH_W-1:0] s_one;
    logic signed [pkcs_pkg::ARITH_W-1:0] s_room;
    logic signed [pkcs_pkg::ARITH_W-1:0] s_sep;
    logic signed [pkcs_pkg::ARITH_W-1:0] s_pfx_end;
    logic signed [pkcs_pkg::ARITH_W-1:0] s_off;
    logic [7:0]                          exp_byte;
    logic [2:0]                          chk_fault;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    assign in_range   = (r_pos <= pkcs_pkg::POS_W'(pkcs_pkg::MAX_KEY_BYTES));
    assign count_next = in_range ? r_pos + pkcs_pkg::POS_W'(1) : r_pos;

    assign s_pos     = $signed(pkcs_pkg::ARITH_W'(r_pos));
    assign s_key     = $signed(pkcs_pkg::ARITH_W'(i_cfg.key_bytes));
    assign s_pl      = $signed(pkcs_pkg::ARITH_W'(pkcs_pkg::prefix_len(i_cfg.hash_select)));
    assign s_dl      = $signed(pkcs_pkg::ARITH_W'(i_cfg.digest_len));
    assign s_one     = $signed(pkcs_pkg::ARITH_W'(1));
    assign s_room    = s_key - s_pl - s_dl;
    assign s_sep     = s_room - s_one;
    assign s_pfx_end = s_sep + s_pl;
    assign s_off     = s_pos - s_sep - s_one;

    always_comb begin
        exp_byte  = pkcs_pkg::BYTE_ZERO;
        chk_fault = pkcs_pkg::FLT_OK;
        if (!in_range) begin
            chk_fault = pkcs_pkg::FLT_OK;
        end else if (r_pos == '0) begin
            chk_fault = pkcs_pkg::FLT_HEADER;
        end else if (r_pos == pkcs_pkg::POS_W'(1)) begin
            exp_byte  = pkcs_pkg::BYTE_ONE;
            chk_fault = pkcs_pkg::FLT_HEADER;
        end else if (s_pos >= s_key) begin
            chk_fault = pkcs_pkg::FLT_OK;     // beyond the key: left to the length check
        end else if (s_pos < s_sep) begin
            exp_byte  = pkcs_pkg::PAD_BYTE;
            chk_fault = pkcs_pkg::FLT_PAD;
        end else if (s_pos == s_sep) begin
            chk_fault = pkcs_pkg::FLT_SEP;
        end else if (s_pos <= s_pfx_end) begin
            exp_byte  = pkcs_pkg::prefix_byte(i_cfg.hash_select,
                                              s_off[pkcs_pkg::PFX_IDX_W-1:0]);
            chk_fault = pkcs_pkg::FLT_PREFIX;
        end else begin
            exp_byte  = i_data.digest_byte;
            chk_fault = pkcs_pkg::FLT_DIGEST;
        end
    end

    always_comb begin
        o_entry.block_byte = i_data.block_byte;
        o_entry.exp_byte   = exp_byte;
        o_entry.chk_fault  = chk_fault;
        o_entry.last       = i_data.last;
        o_entry.len_bad    = (i_cfg.key_bytes == '0) ||
                             (pkcs_pkg::ARITH_W'(i_cfg.key_bytes) >
                              pkcs_pkg::ARITH_W'(pkcs_pkg::MAX_KEY_BYTES)) ||
                             (pkcs_pkg::ARITH_W'(count_next) !=
                              pkcs_pkg::ARITH_W'(i_cfg.key_bytes));
        o_entry.short_key  = (s_room < $signed(pkcs_pkg::ARITH_W'(pkcs_pkg::SHORT_MARGIN)));
    end

    always_comb begin
        n_pos = r_pos;
        if (o_push) begin
            n_pos = i_data.last ? '0 : count_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

>>> rtl/pkcs_queue.sv
// Short register queue between the classifying front and the checking back.
// Depends on pkcs_pkg.
module pkcs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pkcs_pkg::t_qent i_wdata,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output pkcs_pkg::t_qent o_rdata
);

    pkcs_pkg::t_qent              r_mem [pkcs_pkg::QUEUE_DEPTH];
    logic [pkcs_pkg::QPTR_W-1:0]  r_wptr;
    logic [pkcs_pkg::QPTR_W-1:0]  r_rptr;
    logic [pkcs_pkg::QCNT_W-1:0]  r_count;
    logic [pkcs_pkg::QCNT_W-1:0]  n_count;

    assign o_full  = (r_count == pkcs_pkg::QCNT_W'(pkcs_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + pkcs_pkg::QCNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - pkcs_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= r_wptr + pkcs_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + pkcs_pkg::QPTR_W'(1);
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pkcs_pkg::QCNT_W'(pkcs_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");
    a_push_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + pkcs_pkg::QCNT_W'(1)))
        else $error("queue count missed a push");
    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !i_push) |=> (r_count == $past(r_count) - pkcs_pkg::QCNT_W'(1)))
        else $error("queue count missed a pop");
`endif

endmodule

>>> rtl/pkcs_back.sv
// Back end: compares each classified byte, keeps the first fault of the block and
// registers the verdict at the last byte. Depends on pkcs_pkg.
module pkcs_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  pkcs_pkg::t_qent i_entry,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output pkcs_pkg::t_out  o_data
);

    logic [2:0]       r_first_fault;
    logic [2:0]       n_first_fault;
    logic             r_valid;
    logic             n_valid;
    pkcs_pkg::t_out   r_out;
    pkcs_pkg::t_out   n_out;
    logic [2:0]       byte_fault;
    logic [2:0]       eff_fault;
    logic [2:0]       verdict;

    // A non-last byte never needs the output register.
    assign o_pop = !i_empty && (!i_entry.last || !r_valid || i_ready);

    assign byte_fault = ((i_entry.chk_fault != pkcs_pkg::FLT_OK) &&
                         (i_entry.block_byte != i_entry.exp_byte)) ?
                        i_entry.chk_fault : pkcs_pkg::FLT_OK;
    assign eff_fault  = (r_first_fault == pkcs_pkg::FLT_OK) ? byte_fault : r_first_fault;

    always_comb begin
        if (i_entry.len_bad) begin
            verdict = pkcs_pkg::FLT_LENGTH;
        end else if (eff_fault == pkcs_pkg::FLT_HEADER) begin
            verdict = pkcs_pkg::FLT_HEADER;
        end else if (i_entry.short_key) begin
            verdict = pkcs_pkg::FLT_SHORT_KEY;
        end else begin
            verdict = eff_fault;
        end
    end

    always_comb begin
        n_first_fault = r_first_fault;
        n_valid       = r_valid;
        n_out         = r_out;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        if (o_pop) begin
            if (i_entry.last) begin
                n_first_fault = pkcs_pkg::FLT_OK;
                n_valid       = 1'b1;
                n_out.pass    = (verdict == pkcs_pkg::FLT_OK);
                n_out.fault   = verdict;
            end else begin
                n_first_fault = eff_fault;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_fault <= pkcs_pkg::FLT_OK;
            r_valid       <= 1'b0;
        end else begin
            r_first_fault <= n_first_fault;
            r_valid       <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_valid;
    assign o_data  = r_out;

`ifndef ASSERT_OFF
    a_pass_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_out.pass == (r_out.fault == pkcs_pkg::FLT_OK)))
        else $error("pass flag disagrees with fault code");
    a_block_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_entry.last) |=> (r_first_fault == pkcs_pkg::FLT_OK))
        else $error("first fault not cleared after last byte");
    a_length_wins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_entry.last && i_entry.len_bad) |=>
        (r_valid && r_out.fault == pkcs_pkg::FLT_LENGTH))
        else $error("length fault not reported");
`endif

endmodule
